// File: hdl/pts_pkg.sv
// Package for the prism to tetrahedra splitter: transaction payload types,
// field widths, the corner relabeling table and the tetrahedron shapes.
// It has no dependencies; every module of the block imports it.
package pts_pkg;

    localparam int FIELD_BITS         = 32;
    localparam int INDEX_BITS_DEFAULT = 32;
    localparam int NUM_CORNERS        = 6;
    localparam int TETS_PER_PRISM     = 3;
    localparam int TET_CORNERS        = 4;

    localparam logic [1:0] LAST_TET     = 2'd2;
    localparam logic       DIAG_I2_I6   = 1'b0;
    localparam logic       DIAG_I3_I5   = 1'b1;

    typedef logic [2:0] t_pts_corner_sel;

    typedef struct packed {
        logic [FIELD_BITS-1:0] corner_one;
        logic [FIELD_BITS-1:0] corner_two;
        logic [FIELD_BITS-1:0] corner_three;
        logic [FIELD_BITS-1:0] corner_four;
        logic [FIELD_BITS-1:0] corner_five;
        logic [FIELD_BITS-1:0] corner_six;
    } t_pts_in;

    typedef struct packed {
        logic [FIELD_BITS-1:0] tet_vertex_a;
        logic [FIELD_BITS-1:0] tet_vertex_b;
        logic [FIELD_BITS-1:0] tet_vertex_c;
        logic [FIELD_BITS-1:0] tet_vertex_d;
        logic [1:0]            tet_number;
        logic                  diagonal_choice;
        logic                  last_of_prism;
    } t_pts_out;

    // Row is the corner holding the smallest index; entry k is the corner used as I(k+1).
    localparam t_pts_corner_sel RELABEL [NUM_CORNERS][NUM_CORNERS] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5},
        '{3'd1, 3'd2, 3'd0, 3'd4, 3'd5, 3'd3},
        '{3'd2, 3'd0, 3'd1, 3'd5, 3'd3, 3'd4},
        '{3'd3, 3'd5, 3'd4, 3'd0, 3'd2, 3'd1},
        '{3'd4, 3'd3, 3'd5, 3'd1, 3'd0, 3'd2},
        '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0}
    };

    // Tetrahedra as relabeled positions I1..I6, counted from zero, per diagonal.
    localparam t_pts_corner_sel TET_SHAPE [2][TETS_PER_PRISM][TET_CORNERS] = '{
        '{'{3'd0, 3'd1, 3'd2, 3'd5}, '{3'd0, 3'd1, 3'd5, 3'd4}, '{3'd0, 3'd4, 3'd5, 3'd3}},
        '{'{3'd0, 3'd1, 3'd2, 3'd4}, '{3'd0, 3'd4, 3'd2, 3'd5}, '{3'd0, 3'd4, 3'd5, 3'd3}}
    };

endpackage

// File: hdl/pts_min_find.sv
// Two pipeline stages that locate the corner with the smallest index.
// Depends on pts_pkg; ties go to the earliest corner.
module pts_min_find
    import pts_pkg::*;
#(
    parameter int IDX_W = FIELD_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [IDX_W-1:0]       i_v [NUM_CORNERS],
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [IDX_W-1:0]       o_v [NUM_CORNERS],
    output t_pts_corner_sel        o_pos
);

    logic                 r_a_valid;
    logic [IDX_W-1:0]     r_a_v [NUM_CORNERS];
    logic [IDX_W-1:0]     r_a_wv [3];
    t_pts_corner_sel      r_a_wp [3];
    logic                 r_b_valid;
    logic [IDX_W-1:0]     r_b_v [NUM_CORNERS];
    t_pts_corner_sel      r_b_pos;

    logic                 rdy_a;
    logic                 rdy_b;
    logic [IDX_W-1:0]     n_a_wv [3];
    t_pts_corner_sel      n_a_wp [3];
    logic [IDX_W-1:0]     mid_v;
    t_pts_corner_sel      mid_p;
    t_pts_corner_sel      n_b_pos;

    assign rdy_b   = !r_b_valid || !i_stall;
    assign rdy_a   = !r_a_valid || rdy_b;
    assign o_stall = !rdy_a;

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            if (i_v[2*p+1] < i_v[2*p]) begin
                n_a_wv[p] = i_v[2*p+1];
                n_a_wp[p] = t_pts_corner_sel'(2*p+1);
            end else begin
                n_a_wv[p] = i_v[2*p];
                n_a_wp[p] = t_pts_corner_sel'(2*p);
            end
        end
    end

    always_comb begin
        if (r_a_wv[1] < r_a_wv[0]) begin
            mid_v = r_a_wv[1];
            mid_p = r_a_wp[1];
        end else begin
            mid_v = r_a_wv[0];
            mid_p = r_a_wp[0];
        end
        n_b_pos = (r_a_wv[2] < mid_v) ? r_a_wp[2] : mid_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_valid <= i_valid;
            end
            if (rdy_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_v  <= i_v;
            r_a_wv <= n_a_wv;
            r_a_wp <= n_a_wp;
        end
        if (rdy_b) begin
            r_b_v   <= r_a_v;
            r_b_pos <= n_b_pos;
        end
    end

    assign o_valid = r_b_valid;
    assign o_v     = r_b_v;
    assign o_pos   = r_b_pos;

endmodule

// File: hdl/pts_diag_sel.sv
// Two pipeline stages: relabel the prism around its smallest corner, then pick
// the diagonal of the opposite quad face. Depends on pts_pkg.
module pts_diag_sel
    import pts_pkg::*;
#(
    parameter int IDX_W = FIELD_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [IDX_W-1:0]       i_v [NUM_CORNERS],
    input  t_pts_corner_sel        i_pos,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [IDX_W-1:0]       o_lab [NUM_CORNERS],
    output logic                   o_choice
);

    logic                 r_c_valid;
    logic [IDX_W-1:0]     r_c_lab [NUM_CORNERS];
    logic                 r_d_valid;
    logic [IDX_W-1:0]     r_d_lab [NUM_CORNERS];
    logic                 r_d_choice;

    logic                 rdy_c;
    logic                 rdy_d;
    logic [IDX_W-1:0]     n_c_lab [NUM_CORNERS];
    logic [IDX_W-1:0]     best;
    logic                 n_d_choice;

    assign rdy_d   = !r_d_valid || !i_stall;
    assign rdy_c   = !r_c_valid || rdy_d;
    assign o_stall = !rdy_c;

    always_comb begin
        for (int k = 0; k < NUM_CORNERS; k++) begin
            n_c_lab[k] = i_v[RELABEL[i_pos][k]];
        end
    end

    // The face search runs in the order I2, I6, I3, I5 with strict less-than.
    always_comb begin
        best       = r_c_lab[1];
        n_d_choice = DIAG_I2_I6;
        if (r_c_lab[5] < best) begin
            best = r_c_lab[5];
        end
        if (r_c_lab[2] < best) begin
            best       = r_c_lab[2];
            n_d_choice = DIAG_I3_I5;
        end
        if (r_c_lab[4] < best) begin
            n_d_choice = DIAG_I3_I5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (rdy_c) begin
                r_c_valid <= i_valid;
            end
            if (rdy_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c) begin
            r_c_lab <= n_c_lab;
        end
        if (rdy_d) begin
            r_d_lab    <= r_c_lab;
            r_d_choice <= n_d_choice;
        end
    end

    assign o_valid  = r_d_valid;
    assign o_lab    = r_d_lab;
    assign o_choice = r_d_choice;

endmodule

// File: hdl/pts_tet_emit.sv
// Output stage: holds one relabeled prism and sends its three tetrahedra,
// one per result transaction. Depends on pts_pkg.
module pts_tet_emit
    import pts_pkg::*;
#(
    parameter int IDX_W = FIELD_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [IDX_W-1:0]       i_lab [NUM_CORNERS],
    input  logic                   i_choice,
    output logic                   o_valid,
    input  logic                   i_stall,
    output t_pts_out               o_data
);

    logic                 r_valid;
    logic [1:0]           r_tet;
    logic [IDX_W-1:0]     r_lab [NUM_CORNERS];
    logic                 r_choice;

    logic                 sent;
    logic                 load;

    assign sent    = r_valid && !i_stall;
    assign load    = !r_valid || (sent && r_tet == LAST_TET);
    assign o_stall = !load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tet   <= 2'd0;
        end else if (load) begin
            r_valid <= i_valid;
            r_tet   <= 2'd0;
        end else if (sent) begin
            r_tet <= r_tet + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_lab    <= i_lab;
            r_choice <= i_choice;
        end
    end

    always_comb begin
        o_data.tet_vertex_a    = FIELD_BITS'(r_lab[TET_SHAPE[r_choice][r_tet][0]]);
        o_data.tet_vertex_b    = FIELD_BITS'(r_lab[TET_SHAPE[r_choice][r_tet][1]]);
        o_data.tet_vertex_c    = FIELD_BITS'(r_lab[TET_SHAPE[r_choice][r_tet][2]]);
        o_data.tet_vertex_d    = FIELD_BITS'(r_lab[TET_SHAPE[r_choice][r_tet][3]]);
        o_data.tet_number      = r_tet;
        o_data.diagonal_choice = r_choice;
        o_data.last_of_prism   = (r_tet == LAST_TET);
    end

    assign o_valid = r_valid;

endmodule

// File: hdl/prism_to_tetra_split_top.sv
// Top level of the prism to tetrahedra splitter: min search, relabel and
// diagonal pick, and the tetrahedron output stage. Depends on pts_pkg.
//
//   Channel   Direction  Handshake            Payload
//   prism     in         i_valid / o_stall    i_data (t_pts_in)
//   tetra     out        o_valid / i_stall    o_data (t_pts_out)
//
// A prism passes four register stages and reaches the output register; its three
// tetrahedra then leave on three transactions. Over the single output channel,
// the next prism loads into the output stage as the last tetrahedron leaves.
// Synchronous active-low reset empties every stage. A stall on the output holds
// the current tetrahedron and backs the pipeline up stage by stage.
module prism_to_tetra_split_top
    import pts_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_pts_in   i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_pts_out  o_data
);

    localparam int IDX_W = (INDEX_BITS < FIELD_BITS) ? INDEX_BITS : FIELD_BITS;

    logic [IDX_W-1:0]  in_v  [NUM_CORNERS];
    logic [IDX_W-1:0]  min_v [NUM_CORNERS];
    t_pts_corner_sel   min_pos;
    logic              min_valid;
    logic              diag_stall;
    logic [IDX_W-1:0]  diag_lab [NUM_CORNERS];
    logic              diag_choice;
    logic              diag_valid;
    logic              emit_stall;

    assign in_v[0] = i_data.corner_one[IDX_W-1:0];
    assign in_v[1] = i_data.corner_two[IDX_W-1:0];
    assign in_v[2] = i_data.corner_three[IDX_W-1:0];
    assign in_v[3] = i_data.corner_four[IDX_W-1:0];
    assign in_v[4] = i_data.corner_five[IDX_W-1:0];
    assign in_v[5] = i_data.corner_six[IDX_W-1:0];

    pts_min_find #(
        .IDX_W (IDX_W)
    ) u_min_find (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_v     (in_v),
        .o_valid (min_valid),
        .i_stall (diag_stall),
        .o_v     (min_v),
        .o_pos   (min_pos)
    );

    pts_diag_sel #(
        .IDX_W (IDX_W)
    ) u_diag_sel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (min_valid),
        .o_stall  (diag_stall),
        .i_v      (min_v),
        .i_pos    (min_pos),
        .o_valid  (diag_valid),
        .i_stall  (emit_stall),
        .o_lab    (diag_lab),
        .o_choice (diag_choice)
    );

    pts_tet_emit #(
        .IDX_W (IDX_W)
    ) u_tet_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (diag_valid),
        .o_stall  (emit_stall),
        .i_lab    (diag_lab),
        .i_choice (diag_choice),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_data   (o_data)
    );

endmodule
